FILE: src/bcmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bcmp_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_COEF_A = 3'd0;
   localparam logic [2:0] CSR_COEF_B = 3'd1;
   localparam logic [2:0] CSR_COEF_C = 3'd2;
   localparam logic [2:0] CSR_COEF_D = 3'd3;
   localparam logic [2:0] CSR_OSS    = 3'd4;

   // input mode / result kind codes
   localparam logic MODE_TEMP  = 1'b0;
   localparam logic MODE_PRESS = 1'b1;

   // compensation constants
   localparam logic signed [31:0] TEMP_OFFSET = 32'sd4000;
   localparam logic [15:0]        B7_SCALE    = 16'd50000;
   localparam logic signed [32:0] P_COEF_SQ   = 33'sd3038;
   localparam logic signed [32:0] P_COEF_LIN  = -33'sd7357;
   localparam logic signed [33:0] P_ROUND     = 34'sd3791;
   localparam logic [31:0]        X3_BIAS     = 32'd32768;

   // divider request and response
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

FILE: src/bcmp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module bcmp_div
   import bcmp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   localparam logic [5:0] DIV_STEPS = 6'd32;

   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] q_ff, q_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;
   logic [32:0] trial;

   // one quotient bit per cycle, restoring
   always_comb begin
      shifted = {r_ff, q_ff[31]};
      trial   = shifted - {1'b0, dvs_ff};
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      dvs_in  = dvs_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         q_in    = req.dividend;
         r_in    = '0;
         dvs_in  = req.divisor;
         cnt_in  = DIV_STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = shifted[31:0];
            q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = q_ff;

endmodule
`default_nettype wire

FILE: src/barometer_compensation_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Barometer compensation core. Each req_ beat carries a raw reading tagged by mode: a
// temperature reading returns the temperature in 0.1 degree units and keeps its B5 term
// for later pressure readings; a pressure reading returns pascals using the last B5 (zero
// after reset). A zero divisor returns value 0 with divide_error set; a failed temperature
// leaves B5 unchanged. One 33x33 signed multiplier and a radix-2 divider are shared under
// a sequencer; the divider takes most of the time from acceptance to the result register.
// The next beat is taken once the sequencer is back in idle, even while a result waits.
// Coefficients are written through the csr_ port; the user must write them only while
// the core is idle, which the core itself does not enforce.
module barometer_compensation_core
   import bcmp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic [2:0]         csr_index,
   input  wire logic [47:0]        csr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_mode,
   input  wire logic [18:0]        req_raw_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_kind,
   output logic signed [31:0]      rsp_value,
   output logic                    rsp_divide_error
);

   typedef enum logic [18:0] {
      ST_IDLE   = 19'b0000000000000000001,
      ST_T_MUL  = 19'b0000000000000000010,
      ST_T_DEN  = 19'b0000000000000000100,
      ST_P_B6   = 19'b0000000000000001000,
      ST_P_SQ   = 19'b0000000000000010000,
      ST_P_X2A  = 19'b0000000000000100000,
      ST_P_X1A  = 19'b0000000000001000000,
      ST_P_B3   = 19'b0000000000010000000,
      ST_P_X1B  = 19'b0000000000100000000,
      ST_P_X3B  = 19'b0000000001000000000,
      ST_P_M4   = 19'b0000000010000000000,
      ST_P_B7   = 19'b0000000100000000000,
      ST_P_DIVS = 19'b0000001000000000000,
      ST_DIV    = 19'b0000010000000000000,
      ST_P_HH   = 19'b0000100000000000000,
      ST_P_M1   = 19'b0001000000000000000,
      ST_P_M2   = 19'b0010000000000000000,
      ST_P_FIN  = 19'b0100000000000000000,
      ST_DONE   = 19'b1000000000000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [47:0]        coef_a_ff, coef_a_in;
   logic [47:0]        coef_b_ff, coef_b_in;
   logic [31:0]        coef_c_ff, coef_c_in;
   logic [31:0]        coef_d_ff, coef_d_in;
   logic [1:0]         oss_ff, oss_in;
   logic signed [31:0] temp_term_ff, temp_term_in;
   logic               kind_ff, kind_in;
   logic [18:0]        raw_ff, raw_in;
   logic [47:0]        prod_ff, prod_in;
   logic signed [31:0] b6_ff, b6_in;
   logic signed [31:0] sq_ff, sq_in;
   logic signed [31:0] t_ff, t_in;
   logic signed [31:0] b3_ff, b3_in;
   logic [16:0]        b4_ff, b4_in;
   logic signed [31:0] p_ff, p_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] res_ff, res_in;
   logic               err_ff, err_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic               rsp_err_ff, rsp_err_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // coefficient fields
   logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
   logic [15:0]        ac4, ac5, ac6;
   assign ac1 = coef_a_ff[15:0];
   assign ac2 = coef_a_ff[31:16];
   assign ac3 = coef_a_ff[47:32];
   assign ac4 = coef_b_ff[15:0];
   assign ac5 = coef_b_ff[31:16];
   assign ac6 = coef_b_ff[47:32];
   assign b1  = coef_c_ff[15:0];
   assign b2  = coef_c_ff[31:16];
   assign mc  = coef_d_ff[15:0];
   assign md  = coef_d_ff[31:16];

   // shared multiplier operand select
   logic signed [16:0] ut_diff;
   logic [31:0]        b7_diff;
   logic [15:0]        b7_k;
   always_comb begin
      ut_diff = {1'b0, raw_ff[15:0]} - {1'b0, ac6};
      b7_diff = {13'd0, raw_ff} - b3_ff;
      b7_k    = B7_SCALE >> oss_ff;
      mul_a   = '0;
      mul_b   = '0;
      case (state_ff)
         ST_T_MUL: begin
            mul_a = {{16{ut_diff[16]}}, ut_diff};
            mul_b = {17'd0, ac5};
         end
         ST_P_SQ: begin
            mul_a = {b6_ff[31], b6_ff};
            mul_b = {b6_ff[31], b6_ff};
         end
         ST_P_X2A: begin
            mul_a = {{17{ac2[15]}}, ac2};
            mul_b = {b6_ff[31], b6_ff};
         end
         ST_P_X1A: begin
            mul_a = {{17{b2[15]}}, b2};
            mul_b = {sq_ff[31], sq_ff};
         end
         ST_P_B3: begin
            mul_a = {{17{ac3[15]}}, ac3};
            mul_b = {b6_ff[31], b6_ff};
         end
         ST_P_X1B: begin
            mul_a = {{17{b1[15]}}, b1};
            mul_b = {sq_ff[31], sq_ff};
         end
         ST_P_M4: begin
            mul_a = {17'd0, ac4};
            mul_b = {1'b0, t_ff};
         end
         ST_P_B7: begin
            mul_a = {1'b0, b7_diff};
            mul_b = {17'd0, b7_k};
         end
         ST_P_HH: begin
            mul_a = {{9{p_ff[31]}}, p_ff[31:8]};
            mul_b = {{9{p_ff[31]}}, p_ff[31:8]};
         end
         ST_P_M1: begin
            mul_a = {prod_ff[31], prod_ff[31:0]};
            mul_b = P_COEF_SQ;
         end
         ST_P_M2: begin
            mul_a = P_COEF_LIN;
            mul_b = {p_ff[31], p_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p   = mul_a * mul_b;
      prod_in = mul_p[47:0];
   end

   // sequencer and datapath
   logic signed [31:0] x1, x2, x3, den, mcs, b5, b7, quo;
   logic signed [33:0] v34;
   logic signed [37:0] v38;
   logic signed [32:0] s33;
   always_comb begin
      state_in     = state_ff;
      coef_a_in    = coef_a_ff;
      coef_b_in    = coef_b_ff;
      coef_c_in    = coef_c_ff;
      coef_d_in    = coef_d_ff;
      oss_in       = oss_ff;
      temp_term_in = temp_term_ff;
      kind_in      = kind_ff;
      raw_in       = raw_ff;
      b6_in        = b6_ff;
      sq_in        = sq_ff;
      t_in         = t_ff;
      b3_in        = b3_ff;
      b4_in        = b4_ff;
      p_in         = p_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      div_req      = '0;
      x1  = '0;
      x2  = '0;
      x3  = '0;
      den = '0;
      mcs = '0;
      b5  = '0;
      b7  = '0;
      quo = '0;
      v34 = '0;
      v38 = '0;
      s33 = '0;

      if (csr_write) begin
         case (csr_index)
            CSR_COEF_A: coef_a_in = csr_data;
            CSR_COEF_B: coef_b_in = csr_data;
            CSR_COEF_C: coef_c_in = csr_data[31:0];
            CSR_COEF_D: coef_d_in = csr_data[31:0];
            CSR_OSS:    oss_in    = csr_data[1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_mode;
               raw_in   = req_raw_value;
               err_in   = 1'b0;
               state_in = (req_mode == MODE_PRESS) ? ST_P_B6 : ST_T_MUL;
            end
         end
         ST_T_MUL: state_in = ST_T_DEN;
         ST_T_DEN: begin
            x1   = prod_ff[46:15];
            den  = x1 + {{16{md[15]}}, md};
            mcs  = {{5{mc[15]}}, mc, 11'd0};
            t_in = x1;
            if (den == 32'sd0) begin
               res_in   = '0;
               err_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = mcs[31] ? -mcs : mcs;
               div_req.divisor  = den[31] ? -den : den;
               neg_in           = mcs[31] ^ den[31];
               state_in         = ST_DIV;
            end
         end
         ST_P_B6: begin
            b6_in    = temp_term_ff - TEMP_OFFSET;
            state_in = ST_P_SQ;
         end
         ST_P_SQ: state_in = ST_P_X2A;
         ST_P_X2A: begin
            sq_in    = prod_ff[43:12];
            state_in = ST_P_X1A;
         end
         ST_P_X1A: begin
            t_in     = prod_ff[42:11];
            state_in = ST_P_B3;
         end
         ST_P_B3: begin
            x1       = prod_ff[42:11];
            x3       = x1 + t_ff;
            v34      = {{16{ac1[15]}}, ac1, 2'b00} + {{2{x3[31]}}, x3};
            v38      = ({{4{v34[33]}}, v34} << oss_ff) + 38'sd2;
            b3_in    = v38[33:2];
            state_in = ST_P_X1B;
         end
         ST_P_X1B: begin
            t_in     = prod_ff[44:13];
            state_in = ST_P_X3B;
         end
         ST_P_X3B: begin
            x2       = prod_ff[47:16];
            v34      = {{2{t_ff[31]}}, t_ff} + {{2{x2[31]}}, x2} + 34'sd2;
            x3       = v34[33:2];
            t_in     = x3 + X3_BIAS;
            state_in = ST_P_M4;
         end
         ST_P_M4: state_in = ST_P_B7;
         ST_P_B7: begin
            b4_in    = prod_ff[31:15];
            state_in = ST_P_DIVS;
         end
         ST_P_DIVS: begin
            b7 = prod_ff[31:0];
            if (b4_ff == 17'd0) begin
               res_in   = '0;
               err_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = b7[31] ? b7 : {b7[30:0], 1'b0};
               div_req.divisor  = {15'd0, b4_ff};
               neg_in           = b7[31];
               state_in         = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               quo = div_rsp.quotient;
               if (kind_ff == MODE_TEMP) begin
                  x2           = neg_ff ? -quo : quo;
                  b5           = t_ff + x2;
                  temp_term_in = b5;
                  s33          = {b5[31], b5} + 33'sd8;
                  res_in       = {{3{s33[32]}}, s33[32:4]};
                  state_in     = ST_DONE;
               end else begin
                  p_in     = neg_ff ? {quo[30:0], 1'b0} : quo;
                  state_in = ST_P_HH;
               end
            end
         end
         ST_P_HH: state_in = ST_P_M1;
         ST_P_M1: state_in = ST_P_M2;
         ST_P_M2: begin
            t_in     = prod_ff[47:16];
            state_in = ST_P_FIN;
         end
         ST_P_FIN: begin
            x2       = prod_ff[47:16];
            v34      = {{2{t_ff[31]}}, t_ff} + {{2{x2[31]}}, x2} + P_ROUND;
            res_in   = p_ff + {{2{v34[33]}}, v34[33:4]};
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hand over to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_value_in = res_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         coef_a_ff    <= '0;
         coef_b_ff    <= '0;
         coef_c_ff    <= '0;
         coef_d_ff    <= '0;
         oss_ff       <= '0;
         temp_term_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         coef_a_ff    <= coef_a_in;
         coef_b_ff    <= coef_b_in;
         coef_c_ff    <= coef_c_in;
         coef_d_ff    <= coef_d_in;
         oss_ff       <= oss_in;
         temp_term_ff <= temp_term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      raw_ff       <= raw_in;
      prod_ff      <= prod_in;
      b6_ff        <= b6_in;
      sq_ff        <= sq_in;
      t_ff         <= t_in;
      b3_ff        <= b3_in;
      b4_ff        <= b4_in;
      p_ff         <= p_in;
      neg_ff       <= neg_in;
      res_ff       <= res_in;
      err_ff       <= err_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   bcmp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_divide_error = rsp_err_ff;

   // an error beat always carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |-> rsp_value == 32'sd0)
      else $error("divide error beat with nonzero value");

   // the divider is never restarted mid-division
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // while waiting on the divider it is either running or just finished
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_rsp.busy || div_rsp.done)
      else $error("waiting on an idle divider");

   // the result register is only overwritten after its beat was taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("result beat lost");

endmodule
`default_nettype wire

FILE: test/bcmp_result_checker.sv
`timescale 1ns / 1ps
module bcmp_result_checker
   import bcmp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write,
   input  wire logic [2:0]        csr_index,
   input  wire logic [47:0]       csr_data,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic              req_mode,
   input  wire logic [18:0]       req_raw_value,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic              rsp_kind,
   input  wire logic signed [31:0] rsp_value,
   input  wire logic              rsp_divide_error,
   output int                     fail_count,
   output int                     pending
);

   typedef struct {
      logic        kind;
      logic [31:0] value;
      logic        divide_error;
   } reading_type;

   // calibration copy and last good B5 term
   logic [47:0] coef_a, coef_b;
   logic [31:0] coef_c, coef_d;
   logic [1:0]  oss;
   longint      b5_term;
   reading_type readings_q[$];

   function automatic longint wrap32(longint v);
      int t;
      t = int'(v);
      return t;
   endfunction

   function automatic longint sfield(logic [47:0] r, int pos);
      return longint'(shortint'(r[pos +: 16]));
   endfunction

   function automatic longint ufield(logic [47:0] r, int pos);
      return longint'(r[pos +: 16]);
   endfunction

   // compensated reading for one beat; updates b5_term on a good temperature
   function automatic reading_type compensate(logic mode, logic [18:0] raw);
      reading_type r;
      longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      longint x1, x2, x3, den, b5, b6, sq, b3, p, h;
      int unsigned b4, b7, q, t, scale;
      ac1 = sfield(coef_a, 0);
      ac2 = sfield(coef_a, 16);
      ac3 = sfield(coef_a, 32);
      ac4 = ufield(coef_b, 0);
      ac5 = ufield(coef_b, 16);
      ac6 = ufield(coef_b, 32);
      b1  = sfield({16'b0, coef_c}, 0);
      b2  = sfield({16'b0, coef_c}, 16);
      mc  = sfield({16'b0, coef_d}, 0);
      md  = sfield({16'b0, coef_d}, 16);
      r.kind = mode;
      r.value = '0;
      r.divide_error = 1'b0;
      if (mode == MODE_TEMP) begin
         x1 = wrap32(((longint'(raw[15:0]) - ac6) * ac5) >>> 15);
         den = wrap32(x1 + md);
         if (den == 0) begin
            r.divide_error = 1'b1;
         end else begin
            x2 = wrap32((mc * 2048) / den);
            b5 = wrap32(x1 + x2);
            b5_term = b5;
            r.value = 32'(wrap32((b5 + 8) >>> 4));
         end
      end else begin
         b6 = wrap32(b5_term - 4000);
         sq = wrap32((b6 * b6) >>> 12);
         x1 = wrap32((b2 * sq) >>> 11);
         x2 = wrap32((ac2 * b6) >>> 11);
         x3 = wrap32(x1 + x2);
         b3 = wrap32((((ac1 * 4 + x3) << oss) + 2) >>> 2);
         x1 = wrap32((ac3 * b6) >>> 13);
         x2 = wrap32((b1 * sq) >>> 16);
         x3 = wrap32((x1 + x2 + 2) >>> 2);
         t = 32'(x3 + 32768);
         b4 = (32'(ac4) * t) >> 15;
         scale = 32'd50000 >> oss;
         b7 = 32'(longint'(raw) - b3) * scale;
         if (b4 == 0) begin
            r.divide_error = 1'b1;
         end else begin
            if (b7 < 32'h8000_0000) q = (b7 * 2) / b4;
            else q = (b7 / b4) * 2;
            p = wrap32(longint'(q));
            h = p >>> 8;
            x1 = wrap32(h * h);
            x1 = wrap32((x1 * 3038) >>> 16);
            x2 = wrap32((-7357 * p) >>> 16);
            p = wrap32(p + ((x1 + x2 + 3791) >>> 4));
            r.value = 32'(p);
         end
      end
      return r;
   endfunction

   // track config, predict accepted beats, compare results
   always @(posedge clock) begin
      reading_type exp_r;
      if (reset) begin
         coef_a <= '0;
         coef_b <= '0;
         coef_c <= '0;
         coef_d <= '0;
         oss <= '0;
         b5_term = 0;
         readings_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_COEF_A: coef_a <= csr_data;
               CSR_COEF_B: coef_b <= csr_data;
               CSR_COEF_C: coef_c <= csr_data[31:0];
               CSR_COEF_D: coef_d <= csr_data[31:0];
               CSR_OSS:    oss <= csr_data[1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (readings_q.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               exp_r = readings_q.pop_front();
               if (rsp_kind !== exp_r.kind || rsp_value !== exp_r.value
                   || rsp_divide_error !== exp_r.divide_error) begin
                  if (rsp_kind !== exp_r.kind)
                     $error("kind: expected %0d, got %0d", exp_r.kind, rsp_kind);
                  if (rsp_value !== exp_r.value)
                     $error("value: expected %0d, got %0d",
                            $signed(exp_r.value), rsp_value);
                  if (rsp_divide_error !== exp_r.divide_error)
                     $error("divide_error: expected %0d, got %0d",
                            exp_r.divide_error, rsp_divide_error);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            readings_q.push_back(compensate(req_mode, req_raw_value));
         pending <= readings_q.size();
      end
   end

endmodule

FILE: test/tb_barometer_compensation_core.sv
`timescale 1ns / 1ps
module tb_barometer_compensation_core;
   import bcmp_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write = 1'b0;
   logic [2:0]        csr_index = CSR_COEF_A;
   logic [47:0]       csr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_mode = MODE_TEMP;
   logic [18:0]       req_raw_value = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_kind;
   logic signed [31:0] rsp_value;
   logic              rsp_divide_error;
   int                fail_count, pending;
   int                send_idle_pct = 26;
   int                recv_idle_pct = 87;
   int                cycles = 0;

   barometer_compensation_core i_dut (.*);

   bcmp_result_checker i_checker (.*);

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // receiver stalls
   always @(negedge clock)
      rsp_ready <= (reset == 1'b0) && ($urandom_range(99) >= recv_idle_pct);

   task automatic write_csr(logic [2:0] idx, logic [47:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_calibration(logic [47:0] a, logic [47:0] b, logic [31:0] c,
                                   logic [31:0] d, logic [1:0] o);
      write_csr(CSR_COEF_A, a);
      write_csr(CSR_COEF_B, b);
      write_csr(CSR_COEF_C, {16'b0, c});
      write_csr(CSR_COEF_D, {16'b0, d});
      write_csr(CSR_OSS, {46'b0, o});
   endtask

   // one reading beat, with random idle ahead of it
   task automatic send_reading(logic mode, logic [18:0] raw);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_raw_value <= raw;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // mostly plausible readings, some full-range noise
   task automatic random_reading;
      logic        mode;
      logic [18:0] raw;
      mode = 1'($urandom_range(1));
      if ($urandom_range(3) == 0) raw = 19'($urandom);
      else if (mode == MODE_TEMP) raw = 19'(27898 + $urandom_range(8000) - 4000);
      else raw = 19'((23843 + $urandom_range(20000) - 10000) << $urandom_range(3));
      send_reading(mode, raw);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // pressure before any temperature, zero calibration
      send_reading(MODE_PRESS, 19'd40000);
      send_reading(MODE_TEMP, 19'd27898);
      drain();

      // typical calibration, directed extremes
      load_calibration({16'd51841, 16'd65464, 16'd408}, {16'd23153, 16'd32757, 16'd32741},
                       {16'd4, 16'd6190}, {16'd2868, 16'd56825}, 2'd0);
      send_reading(MODE_TEMP, 19'd27898);
      send_reading(MODE_PRESS, 19'd23843);
      send_reading(MODE_TEMP, 19'd0);
      send_reading(MODE_PRESS, 19'd0);
      send_reading(MODE_TEMP, 19'h7FFFF);
      send_reading(MODE_PRESS, 19'h7FFFF);
      send_reading(MODE_TEMP, 19'h0FFFF);
      send_reading(MODE_PRESS, 19'h40000);
      send_reading(MODE_TEMP, 19'h08000);
      send_reading(MODE_PRESS, 19'h2AAAA);
      send_reading(MODE_TEMP, 19'h55555);
      send_reading(MODE_PRESS, 19'h15555);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin send_idle_pct = 26; recv_idle_pct = 87; end
            1: begin send_idle_pct = 87; recv_idle_pct = 26; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         case (phase)
            0: load_calibration({16'd51841, 16'd65464, 16'd408},
                                {16'd23153, 16'd32757, 16'd32741},
                                {16'd4, 16'd6190}, {16'd2868, 16'd56825}, 2'd3);
            1: load_calibration('1, '1, '1, '1, 2'd3);
            2: load_calibration('0, '0, '0, '0, 2'd1);
            3: load_calibration({16'h8000, 16'h7FFF, 16'h8000}, {16'hFFFF, 16'h0000, 16'hFFFF},
                                {16'h7FFF, 16'h8000}, {16'h0000, 16'h8000}, 2'd2);
            default: load_calibration(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                      $urandom, $urandom, 2'($urandom_range(3)));
         endcase
         for (int n = 0; n < 125; n++) begin
            // hold off once until every result is back
            if (phase == 1 && n == 60) drain();
            random_reading();
         end
         drain();
      end

      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
